>>> rtl/core/assert_macros.svh
// Assertion helpers; the clock is taken to be clk and the reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Types and constants shared by the interrupt presenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

  localparam int unsigned SRC_W  = 24;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned WORD_W = 32;

  localparam logic [PRIO_W-1:0] PRIO_LEAST  = 8'hff;
  localparam logic [SRC_W-1:0]  SRC_NONE    = 24'd0;
  localparam logic [SRC_W-1:0]  IPI_SRC_RST = 24'd2;

  typedef enum logic [2:0] {
    K_SET_CPPR = 3'd0,
    K_SET_MFRR = 3'd1,
    K_ACCEPT   = 3'd2,
    K_EOI      = 3'd3,
    K_POLL     = 3'd4,
    K_OFFER    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [PRIO_W-1:0] priority_value;
    logic [WORD_W-1:0] eoi_word;
    logic [SRC_W-1:0]  source_number;
  } item_t;

  typedef struct packed {
    logic [PRIO_W-1:0] cur_prio;
    logic [SRC_W-1:0]  pend_src;
    logic [PRIO_W-1:0] pend_prio;
    logic [PRIO_W-1:0] ipi_prio;
    logic              pend_from_src;
    logic              line;
  } pres_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [PRIO_W-1:0] mfrr_read;
    logic              interrupt_line;
    logic              reject_valid;
    logic [SRC_W-1:0]  reject_source;
    logic              eoi_valid;
    logic [SRC_W-1:0]  eoi_source;
    logic              resend_request;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ipc_step.sv
// ----------------------------------------------------------------------------
// ipc_step
// Next presenter state and result for one item, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_step (
  input  ipc_pkg::item_t                item,
  input  ipc_pkg::pres_state_t          st,
  input  logic [ipc_pkg::SRC_W-1:0]     ipi_num,
  output ipc_pkg::pres_state_t          ns,
  output ipc_pkg::result_t              res
);
  import ipc_pkg::*;

  logic [PRIO_W-1:0] prio;
  logic [PRIO_W-1:0] eoi_prio;
  logic [PRIO_W-1:0] ipi_eff;
  logic              have_pend;
  logic              post_blk;
  logic              post_rej;

  assign prio      = item.priority_value;
  assign eoi_prio  = item.eoi_word[WORD_W-1:SRC_W];
  assign have_pend = (st.pend_src != SRC_NONE);
  // a set-mfrr item posts with its own new priority
  assign ipi_eff   = (item.kind == K_SET_MFRR) ? prio : st.ipi_prio;
  assign post_blk  = have_pend && (st.pend_prio <= ipi_eff);
  assign post_rej  = !post_blk && have_pend && st.pend_from_src;

  always_comb begin
    logic do_post;
    do_post = 1'b0;
    ns      = st;
    res     = '0;

    unique case (item.kind)
      K_SET_CPPR: begin
        ns.cur_prio = prio;
        if (prio < st.cur_prio) begin
          if (have_pend && (prio <= st.pend_prio)) begin
            res.reject_valid  = st.pend_from_src;
            res.reject_source = st.pend_from_src ? st.pend_src : SRC_NONE;
            ns.pend_src       = SRC_NONE;
            ns.pend_prio      = PRIO_LEAST;
            ns.pend_from_src  = 1'b0;
            ns.line           = 1'b0;
          end
        end else if (!have_pend) begin
          res.resend_request = 1'b1;
          do_post            = (st.ipi_prio < prio);
        end
      end
      K_SET_MFRR: begin
        ns.ipi_prio = prio;
        do_post     = (prio < st.cur_prio);
      end
      K_ACCEPT: begin
        res.read_data    = {st.cur_prio, st.pend_src};
        ns.line          = 1'b0;
        ns.cur_prio      = st.pend_prio;
        ns.pend_src      = SRC_NONE;
        ns.pend_prio     = PRIO_LEAST;
        ns.pend_from_src = 1'b0;
      end
      K_EOI: begin
        ns.cur_prio    = eoi_prio;
        res.eoi_valid  = 1'b1;
        res.eoi_source = item.eoi_word[SRC_W-1:0];
        if (!have_pend) begin
          res.resend_request = 1'b1;
          do_post            = (st.ipi_prio < eoi_prio);
        end
      end
      K_POLL: begin
        res.read_data = {st.cur_prio, st.pend_src};
        res.mfrr_read = st.ipi_prio;
      end
      K_OFFER: begin
        if ((prio >= st.cur_prio) || (have_pend && (st.pend_prio <= prio))) begin
          res.reject_valid  = 1'b1;
          res.reject_source = item.source_number;
        end else begin
          res.reject_valid  = have_pend && st.pend_from_src;
          res.reject_source = (have_pend && st.pend_from_src) ? st.pend_src : SRC_NONE;
          ns.pend_src       = item.source_number;
          ns.pend_from_src  = 1'b1;
          ns.pend_prio      = prio;
          ns.line           = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // IPI posting: displaces a less favoured pending interrupt
    if (do_post && !post_blk) begin
      if (post_rej) begin
        res.reject_valid  = 1'b1;
        res.reject_source = st.pend_src;
      end
      ns.pend_src      = ipi_num;
      ns.pend_prio     = ipi_eff;
      ns.pend_from_src = 1'b0;
      ns.line          = 1'b1;
    end

    res.interrupt_line = ns.line;
  end

endmodule

`default_nettype wire

>>> rtl/core/interrupt_presentation_controller.sv
// ----------------------------------------------------------------------------
// interrupt_presentation_controller
// Per-processor interrupt presenter: priority registers, one pending
// interrupt, IPI posting, reject / EOI / resend reporting.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    kind, priority, eoi word, source
//   out      source     out_valid/out_ready  read data, line, reject, eoi, resend
//   cfg      sink       cfg_write_en         IPI source number (24 bits)
//
// One item per cycle while the output is not stalled; each accepted item passes the
// input register, then the result register.
// The step logic between the two registers updates the presenter state as
// the result is written. A stalled result register holds the input register,
// and in_ready drops only when both are full. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_presentation_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic [ipc_pkg::PRIO_W-1:0]    in_priority_value,
  input  logic [ipc_pkg::WORD_W-1:0]    in_eoi_word,
  input  logic [ipc_pkg::SRC_W-1:0]     in_source_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ipc_pkg::WORD_W-1:0]    out_read_data,
  output logic [ipc_pkg::PRIO_W-1:0]    out_mfrr_read,
  output logic                          out_interrupt_line,
  output logic                          out_reject_valid,
  output logic [ipc_pkg::SRC_W-1:0]     out_reject_source,
  output logic                          out_eoi_valid,
  output logic [ipc_pkg::SRC_W-1:0]     out_eoi_source,
  output logic                          out_resend_request,
  input  logic                          cfg_write_en,
  input  logic [ipc_pkg::SRC_W-1:0]     cfg_write_data
);
  import ipc_pkg::*;

  logic              in_valid_r;
  item_t             item_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  pres_state_t       st_r;
  pres_state_t       st_nxt;
  logic [SRC_W-1:0]  ipi_num_r;
  logic              adv;
  logic              fire;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;

  ipc_step u_step (
    .item    (item_r),
    .st      (st_r),
    .ipi_num (ipi_num_r),
    .ns      (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ipi_num_r   <= IPI_SRC_RST;
      st_r        <= '{cur_prio: '0, pend_src: SRC_NONE, pend_prio: PRIO_LEAST,
                       ipi_prio: PRIO_LEAST, pend_from_src: 1'b0, line: 1'b0};
    end else begin
      if (cfg_write_en) begin
        ipi_num_r <= cfg_write_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= '{kind: in_kind, priority_value: in_priority_value,
                  eoi_word: in_eoi_word, source_number: in_source_number};
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = res_r.read_data;
  assign out_mfrr_read      = res_r.mfrr_read;
  assign out_interrupt_line = res_r.interrupt_line;
  assign out_reject_valid   = res_r.reject_valid;
  assign out_reject_source  = res_r.reject_source;
  assign out_eoi_valid      = res_r.eoi_valid;
  assign out_eoi_source     = res_r.eoi_source;
  assign out_resend_request = res_r.resend_request;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_clears, fire && (item_r.kind == K_ACCEPT), !st_r.line && (st_r.pend_src == SRC_NONE) && (st_r.pend_prio == PRIO_LEAST))
  `ASSERT_NEXT(a_stage_holds, in_valid_r && !adv, in_valid_r && $stable(item_r))
  `ASSERT_IMPL(a_src_prio, st_r.pend_from_src, st_r.pend_prio != PRIO_LEAST)

endmodule

`default_nettype wire
